// ----- rtl/tdpu_pkg.sv -----
// Shared types, codes and datapath functions of the Thumb data-processing unit.
package tdpu_pkg;

   // Bit positions in the NZCV flag word
   localparam int FLAG_N = 3;
   localparam int FLAG_Z = 2;
   localparam int FLAG_C = 1;
   localparam int FLAG_V = 0;

   // Instruction format match codes
   localparam logic [2:0] FMT_SHIFT_TOP = 3'b000;
   localparam logic [1:0] FMT_SHIFT_ADDSUB = 2'b11;
   localparam logic [4:0] FMT_ADDSUB_TOP = 5'b00011;
   localparam logic [2:0] FMT_IMM_TOP = 3'b001;
   localparam logic [5:0] FMT_ALU_TOP = 6'b010000;

   localparam logic [7:0] ROT_AMT_WORD = 8'd32;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0,
      SH_LSR = 2'd1,
      SH_ASR = 2'd2,
      SH_ROR = 2'd3
   } shift_kind_type;

   typedef enum logic [1:0] {
      IMM_MOV = 2'd0,
      IMM_CMP = 2'd1,
      IMM_ADD = 2'd2,
      IMM_SUB = 2'd3
   } imm_op_type;

   typedef enum logic [3:0] {
      ALU_AND = 4'd0,
      ALU_EOR = 4'd1,
      ALU_LSL = 4'd2,
      ALU_LSR = 4'd3,
      ALU_ASR = 4'd4,
      ALU_ADC = 4'd5,
      ALU_SBC = 4'd6,
      ALU_ROR = 4'd7,
      ALU_TST = 4'd8,
      ALU_NEG = 4'd9,
      ALU_CMP = 4'd10,
      ALU_CMN = 4'd11,
      ALU_ORR = 4'd12,
      ALU_MUL = 4'd13,
      ALU_BIC = 4'd14,
      ALU_MVN = 4'd15
   } alu_op_type;

   typedef struct packed {
      logic        c;
      logic [31:0] r;
   } shift_res_type;

   typedef struct packed {
      logic [3:0]  fl;
      logic [31:0] r;
   } add_res_type;

   // Result of one executed instruction
   typedef struct packed {
      logic        ok;
      logic        wr;
      logic [2:0]  rd;
      logic [31:0] val;
      logic [3:0]  fl;
   } exe_res_type;

   function automatic logic [1:0] nz_of(logic [31:0] r);
      nz_of = {r[31], (r == 32'd0)};
   endfunction

   function automatic logic [3:0] logic_flags(logic [31:0] r, logic c, logic v);
      logic_flags = {nz_of(r), c, v};
   endfunction

   // Barrel shifter with ARM carry-out; an amount of zero keeps value and carry
   function automatic shift_res_type barrel(logic [31:0] x, logic [7:0] n,
                                            shift_kind_type k, logic cin);
      logic [32:0]        t33;
      logic signed [32:0] s33;
      logic [63:0]        t64;
      shift_res_type      res;
      res.c = cin;
      res.r = x;
      t33   = '0;
      s33   = '0;
      t64   = '0;
      if (n != 8'd0) begin
         case (k)
            SH_LSL: begin
               t33   = {1'b0, x} << n;
               res.c = t33[32];
               res.r = t33[31:0];
            end
            SH_LSR: begin
               t33   = {x, 1'b0} >> n;
               res.c = t33[0];
               res.r = t33[32:1];
            end
            SH_ASR: begin
               s33   = $signed({x, 1'b0}) >>> n;
               res.c = s33[0];
               res.r = s33[32:1];
            end
            SH_ROR: begin
               if (n[4:0] == 5'd0) begin
                  res.c = x[31];
               end else begin
                  t64   = {x, x} >> n[4:0];
                  res.r = t64[31:0];
                  res.c = t64[31];
               end
            end
            default: begin
               res.c = cin;
            end
         endcase
      end
      barrel = res;
   endfunction

   // a + b + cin with ARM carry and overflow
   function automatic add_res_type add_carry(logic [31:0] a, logic [31:0] b, logic cin);
      logic [32:0] s;
      logic        v;
      add_res_type res;
      s      = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      v      = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
      res.r  = s[31:0];
      res.fl = {nz_of(s[31:0]), s[32], v};
      add_carry = res;
   endfunction

endpackage

// ----- rtl/thumb_data_processing_unit_top.sv -----
// Top level of the Thumb data-processing unit: operand read, execute and result register.
// A request is held in the operand stage, then executed into the response register.
// Throughput: one request per cycle while no response stalls; the register file and flags
//    are written in the same cycle the instruction executes; operand reads bypass that write.
// A stalled response holds the execute stage, which in turn holds the request side.
// Reset (synchronous, active high) clears the eight low registers to zero through
//    per-entry valid bits, clears NZCV and empties both pipeline stages at once.
module thumb_data_processing_unit_top
   import tdpu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] dest_index, [34:3] dest_value,
                                    // [38:35] flags_out, [39] zero
   output logic [1:0]  rsp_tuser    // [0] supported, [1] reg_written
);

   // Operand stage
   logic        s1_vld_ff, s1_vld_in;
   logic [15:0] instr_ff;
   logic [31:0] opa_ff;             // Rs / Rn, from instruction bits 5:3
   logic [31:0] opb_ff;             // second operand, address chosen by format

   // Architectural state
   logic [31:0] gpr_mem [8];
   logic [7:0]  reg_vld_ff;
   logic [3:0]  flags_ff;

   // Response register
   logic        rsp_vld_ff, rsp_vld_in;
   logic [39:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic        req_accept;
   logic        exe_advance;
   logic [2:0]  rd_a_addr;
   logic [2:0]  rd_b_addr;
   logic        fwd_a;
   logic        fwd_b;
   exe_res_type exe;

   // Advance the execute stage whenever the response register is free or draining
   assign exe_advance = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready  = !s1_vld_ff || exe_advance;
   assign req_accept  = req_tvalid && req_tready;

   // Pick the second read address from the incoming format
   always_comb begin
      rd_a_addr = req_tdata[5:3];
      if (req_tdata[15:11] == FMT_ADDSUB_TOP) begin
         rd_b_addr = req_tdata[8:6];
      end else if (req_tdata[15:13] == FMT_IMM_TOP) begin
         rd_b_addr = req_tdata[10:8];
      end else begin
         rd_b_addr = req_tdata[2:0];
      end
   end

   // Bypass the register being written by the executing instruction
   assign fwd_a = exe_advance && exe.ok && exe.wr && (exe.rd == rd_a_addr);
   assign fwd_b = exe_advance && exe.ok && exe.wr && (exe.rd == rd_b_addr);

   assign s1_vld_in  = req_accept ? 1'b1 : (exe_advance ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = exe_advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   // Execute: decode, shift, add, logic or multiply, and flag update
   always_comb begin
      logic [15:0]   ins;
      logic          cin;
      logic [7:0]    amt;
      logic [31:0]   op2;
      logic [31:0]   imm;
      shift_res_type sh;
      add_res_type   ad;
      ins = instr_ff;
      cin = flags_ff[FLAG_C];
      amt = '0;
      op2 = '0;
      imm = {24'd0, ins[7:0]};
      sh  = '0;
      ad  = '0;
      exe.ok  = 1'b1;
      exe.wr  = 1'b1;
      exe.rd  = ins[2:0];
      exe.val = '0;
      exe.fl  = flags_ff;
      if (ins[15:13] == FMT_SHIFT_TOP && ins[12:11] != FMT_SHIFT_ADDSUB) begin
         // Shift by immediate; LSR/ASR #0 encode a shift of 32
         amt = {3'd0, ins[10:6]};
         if (amt == 8'd0 && shift_kind_type'(ins[12:11]) != SH_LSL) begin
            amt = ROT_AMT_WORD;
         end
         sh      = barrel(opa_ff, amt, shift_kind_type'(ins[12:11]), cin);
         exe.val = sh.r;
         exe.fl  = logic_flags(sh.r, sh.c, flags_ff[FLAG_V]);
      end else if (ins[15:11] == FMT_ADDSUB_TOP) begin
         op2 = ins[10] ? {29'd0, ins[8:6]} : opb_ff;
         if (ins[9]) begin
            ad = add_carry(opa_ff, ~op2, 1'b1);
         end else begin
            ad = add_carry(opa_ff, op2, 1'b0);
         end
         exe.val = ad.r;
         exe.fl  = ad.fl;
      end else if (ins[15:13] == FMT_IMM_TOP) begin
         exe.rd = ins[10:8];
         unique case (imm_op_type'(ins[12:11]))
            IMM_MOV: begin
               exe.val = imm;
               exe.fl  = logic_flags(imm, cin, flags_ff[FLAG_V]);
            end
            IMM_CMP: begin
               ad      = add_carry(opb_ff, ~imm, 1'b1);
               exe.val = ad.r;
               exe.fl  = ad.fl;
               exe.wr  = 1'b0;
            end
            IMM_ADD: begin
               ad      = add_carry(opb_ff, imm, 1'b0);
               exe.val = ad.r;
               exe.fl  = ad.fl;
            end
            IMM_SUB: begin
               ad      = add_carry(opb_ff, ~imm, 1'b1);
               exe.val = ad.r;
               exe.fl  = ad.fl;
            end
            default: begin
               exe.val = '0;
            end
         endcase
      end else if (ins[15:10] == FMT_ALU_TOP) begin
         // opb holds Rd, opa holds Rs
         unique case (alu_op_type'(ins[9:6])) inside
            ALU_AND, ALU_TST: begin
               exe.val = opb_ff & opa_ff;
               exe.fl  = logic_flags(exe.val, cin, flags_ff[FLAG_V]);
               exe.wr  = (alu_op_type'(ins[9:6]) == ALU_AND);
            end
            ALU_EOR: begin
               exe.val = opb_ff ^ opa_ff;
               exe.fl  = logic_flags(exe.val, cin, flags_ff[FLAG_V]);
            end
            ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
               unique case (alu_op_type'(ins[9:6]))
                  ALU_LSL: sh = barrel(opb_ff, opa_ff[7:0], SH_LSL, cin);
                  ALU_LSR: sh = barrel(opb_ff, opa_ff[7:0], SH_LSR, cin);
                  ALU_ASR: sh = barrel(opb_ff, opa_ff[7:0], SH_ASR, cin);
                  default: sh = barrel(opb_ff, opa_ff[7:0], SH_ROR, cin);
               endcase
               exe.val = sh.r;
               exe.fl  = logic_flags(sh.r, sh.c, flags_ff[FLAG_V]);
            end
            ALU_ADC: begin
               ad      = add_carry(opb_ff, opa_ff, cin);
               exe.val = ad.r;
               exe.fl  = ad.fl;
            end
            ALU_SBC: begin
               ad      = add_carry(opb_ff, ~opa_ff, cin);
               exe.val = ad.r;
               exe.fl  = ad.fl;
            end
            ALU_NEG: begin
               ad      = add_carry(32'd0, ~opa_ff, 1'b1);
               exe.val = ad.r;
               exe.fl  = ad.fl;
            end
            ALU_CMP: begin
               ad      = add_carry(opb_ff, ~opa_ff, 1'b1);
               exe.val = ad.r;
               exe.fl  = ad.fl;
               exe.wr  = 1'b0;
            end
            ALU_CMN: begin
               ad      = add_carry(opb_ff, opa_ff, 1'b0);
               exe.val = ad.r;
               exe.fl  = ad.fl;
               exe.wr  = 1'b0;
            end
            ALU_ORR: begin
               exe.val = opb_ff | opa_ff;
               exe.fl  = logic_flags(exe.val, cin, flags_ff[FLAG_V]);
            end
            ALU_MUL: begin
               // Keep the low word; clear C, keep V
               exe.val = opb_ff * opa_ff;
               exe.fl  = logic_flags(exe.val, 1'b0, flags_ff[FLAG_V]);
            end
            ALU_BIC: begin
               exe.val = opb_ff & ~opa_ff;
               exe.fl  = logic_flags(exe.val, cin, flags_ff[FLAG_V]);
            end
            ALU_MVN: begin
               exe.val = ~opa_ff;
               exe.fl  = logic_flags(exe.val, cin, flags_ff[FLAG_V]);
            end
            default: begin
               exe.val = '0;
            end
         endcase
      end else begin
         // Unsupported word: report zeros and the current flags, change nothing
         exe.ok = 1'b0;
         exe.wr = 1'b0;
         exe.rd = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         flags_ff   <= '0;
         reg_vld_ff <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (exe_advance && exe.ok) begin
            flags_ff <= exe.fl;
            if (exe.wr) begin
               reg_vld_ff[exe.rd] <= 1'b1;
            end
         end
      end
   end

   // Register file write and registered operand read with bypass
   always_ff @(posedge clock) begin
      if (exe_advance && exe.ok && exe.wr) begin
         gpr_mem[exe.rd] <= exe.val;
      end
      if (req_accept) begin
         instr_ff <= req_tdata;
         opa_ff   <= fwd_a ? exe.val : (reg_vld_ff[rd_a_addr] ? gpr_mem[rd_a_addr] : '0);
         opb_ff   <= fwd_b ? exe.val : (reg_vld_ff[rd_b_addr] ? gpr_mem[rd_b_addr] : '0);
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (exe_advance) begin
         rsp_data_ff <= {1'b0, exe.fl, exe.val, exe.rd};
         rsp_user_ff <= {exe.wr, exe.ok};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A register write is only ever reported for a supported instruction
   a_wr_needs_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || !rsp_tuser[1]))
      else $error("register write reported for unsupported instruction");

   // Unsupported responses carry a zero value
   a_unsup_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[34:3] == 32'd0))
      else $error("unsupported instruction returned nonzero value");

   // Flags and register validity move only when an instruction executes
   a_flags_hold : assert property (@(posedge clock) disable iff (reset)
      !exe_advance |=> ($stable(flags_ff) && $stable(reg_vld_ff)))
      else $error("state changed without an executing instruction");

   // An unsupported instruction leaves the flags alone
   a_unsup_state : assert property (@(posedge clock) disable iff (reset)
      (exe_advance && !exe.ok) |=> $stable(flags_ff))
      else $error("unsupported instruction changed the flags");

endmodule
